// ===== rtl/wrom_pkg.sv =====
// Shared types, sizes and helper functions for the outline marker.
// Depends on nothing; every other file imports it.
package wrom_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int QDEPTH       = 4;
    localparam int QAW          = $clog2(QDEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

    typedef logic [23:0] t_pix;

    localparam t_pix WHITE_PIX = 24'hFFFFFF;
    localparam t_pix MARK_PIX  = 24'hFF0000;

    // One input pixel with its neighbourhood, captured at accept.
    typedef struct packed {
        t_pix pix;
        t_pix up;
        t_pix old;
        t_pix al;
        t_pix cw0;
        t_pix cw1;
        logic r1;
        logic r2;
        logic c1;
        logic c2;
        logic rt_ok;
        logic last_row;
        logic frame_last;
    } t_desc;

    // All result pixels caused by one input pixel.
    typedef struct packed {
        logic [2:0][23:0] pix;
        logic [1:0]       last_idx;
        logic             fend;
    } t_group;

    typedef struct packed {
        logic   valid;
        t_group grp;
    } t_push;

    typedef struct packed {
        logic           empty;
        logic [QAW:0]   count;
    } t_qstat;

    function automatic logic f_white(input logic ok, input t_pix p);
        return ok && (p == WHITE_PIX);
    endfunction

    function automatic t_pix f_decide(input t_pix self,
                                      input logic up_ok, input t_pix up,
                                      input logic dn_ok, input t_pix dn,
                                      input logic lf_ok, input t_pix lf,
                                      input logic rt_ok, input t_pix rt);
        logic hit;
        hit = f_white(up_ok, up) || f_white(dn_ok, dn) ||
              f_white(lf_ok, lf) || f_white(rt_ok, rt);
        if (self == WHITE_PIX) begin
            return self;
        end
        return hit ? MARK_PIX : self;
    endfunction

endpackage

// ===== rtl/wrom_front.sv =====
// Front part: accepts pixels, keeps position, line buffers and window,
// and classifies each pixel into a group of result pixels. Uses wrom_pkg.
module wrom_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [wrom_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wrom_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  wrom_pkg::t_pix               i_pix,
    input  wrom_pkg::t_qstat             i_qstat,
    output wrom_pkg::t_push              o_push
);
    import wrom_pkg::*;

    logic [COL_W-1:0] r_w_last;
    logic [ROW_W-1:0] r_h_last;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    t_pix r_prev_mem [MAX_WIDTH];
    t_pix r_old_mem  [MAX_WIDTH];
    t_pix r_rd_prev, r_rd_old;
    t_pix r_byp_pix, r_byp_old;
    logic r_byp;

    t_pix r_al, r_cw0, r_cw1;
    t_desc r_s1;
    logic  r_s1_v;

    logic             acc;
    logic             last_col;
    logic [COL_W-1:0] raddr;
    t_pix             up_c, old_c;
    logic [QAW+1:0]   occ;
    logic [WIDTH_REG_W-1:0]  wv;
    logic [HEIGHT_REG_W-1:0] hv;
    t_desc            desc;

    assign occ        = {1'b0, i_qstat.count} + {{(QAW+1){1'b0}}, r_s1_v};
    assign o_in_ready = (occ < (QAW+2)'(QDEPTH));
    assign acc        = i_in_valid && o_in_ready;
    assign last_col   = (r_col == r_w_last);
    // Read ahead one column; wrap to column 0 at row end for the next row.
    assign raddr      = last_col ? '0 : r_col + COL_W'(1);
    assign up_c       = r_byp ? r_byp_pix : r_rd_prev;
    assign old_c      = r_byp ? r_byp_old : r_rd_old;
    assign wv         = i_cfg_data[WIDTH_REG_W-1:0];
    assign hv         = i_cfg_data[HEIGHT_REG_W-1:0];

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = (r_row == r_h_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_comb begin
        desc.pix        = i_pix;
        desc.up         = up_c;
        desc.old        = old_c;
        desc.al         = r_al;
        desc.cw0        = r_cw0;
        desc.cw1        = r_cw1;
        desc.r1         = (r_row != '0);
        desc.r2         = (r_row > ROW_W'(1));
        desc.c1         = (r_col != '0);
        desc.c2         = (r_col > COL_W'(1));
        desc.rt_ok      = !last_col;
        desc.last_row   = (r_row == r_h_last);
        desc.frame_last = (r_row == r_h_last) && last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= '0;
            r_h_last <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_s1_v   <= 1'b0;
            r_byp    <= 1'b0;
        end else begin
            r_s1_v <= acc;
            if (acc) begin
                r_byp <= last_col && (r_col == '0);
            end
            if (i_cfg_we && (i_cfg_idx == CFG_WIDTH || i_cfg_idx == CFG_HEIGHT)) begin
                r_col <= '0;
                r_row <= '0;
                if (i_cfg_idx == CFG_WIDTH) begin
                    if (wv == '0) begin
                        r_w_last <= '0;
                    end else if (wv > WIDTH_REG_W'(MAX_WIDTH)) begin
                        r_w_last <= COL_W'(MAX_WIDTH - 1);
                    end else begin
                        r_w_last <= COL_W'(wv - WIDTH_REG_W'(1));
                    end
                end else begin
                    if (hv == '0) begin
                        r_h_last <= '0;
                    end else if (hv > HEIGHT_REG_W'(MAX_HEIGHT)) begin
                        r_h_last <= ROW_W'(MAX_HEIGHT - 1);
                    end else begin
                        r_h_last <= ROW_W'(hv - HEIGHT_REG_W'(1));
                    end
                end
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Line buffers: one write and one read-ahead per beat, read data held.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_prev_mem[r_col] <= i_pix;
            r_old_mem[r_col]  <= up_c;
            r_rd_prev         <= r_prev_mem[raddr];
            r_rd_old          <= r_old_mem[raddr];
            r_byp_pix         <= i_pix;
            r_byp_old         <= up_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_al  <= up_c;
            r_cw1 <= r_cw0;
            r_cw0 <= i_pix;
            r_s1  <= desc;
        end
    end

    // Classify: right neighbour above is the read-ahead data of this beat.
    always_comb begin
        t_pix       a_pix, b_pix, c_pix;
        logic       a_on, b_on, c_on;
        logic [1:0] n;
        a_on  = r_s1.r1;
        b_on  = r_s1.last_row && r_s1.c1;
        c_on  = r_s1.frame_last;
        a_pix = f_decide(r_s1.up, r_s1.r2, r_s1.old, 1'b1, r_s1.pix,
                         r_s1.c1, r_s1.al, r_s1.rt_ok, up_c);
        b_pix = f_decide(r_s1.cw0, r_s1.r1, r_s1.al, 1'b0, '0,
                         r_s1.c2, r_s1.cw1, 1'b1, r_s1.pix);
        c_pix = f_decide(r_s1.pix, r_s1.r1, r_s1.up, 1'b0, '0,
                         r_s1.c1, r_s1.cw0, 1'b0, '0);
        o_push.grp.pix = '0;
        n = '0;
        if (a_on) begin
            o_push.grp.pix[n] = a_pix;
            n = n + 2'd1;
        end
        if (b_on) begin
            o_push.grp.pix[n] = b_pix;
            n = n + 2'd1;
        end
        if (c_on) begin
            o_push.grp.pix[n] = c_pix;
            n = n + 2'd1;
        end
        o_push.grp.last_idx = n - 2'd1;
        o_push.grp.fend     = c_on;
        o_push.valid        = r_s1_v && (a_on || b_on || c_on);
    end

endmodule

// ===== rtl/wrom_queue.sv =====
// Short queue of result groups between the front and back parts.
// Uses wrom_pkg for the group type and depth.
module wrom_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrom_pkg::t_push   i_push,
    input  logic              i_pop,
    output wrom_pkg::t_group  o_head,
    output wrom_pkg::t_qstat  o_qstat
);
    import wrom_pkg::*;

    t_group          r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp, r_rp;
    logic [QAW:0]    r_cnt, n_cnt;

    assign o_head        = r_mem[r_rp];
    assign o_qstat.count = r_cnt;
    assign o_qstat.empty = (r_cnt == '0);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push.valid && !i_pop) begin
            n_cnt = r_cnt + (QAW+1)'(1);
        end else if (!i_push.valid && i_pop) begin
            n_cnt = r_cnt - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push.valid) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.grp;
        end
    end

endmodule

// ===== rtl/wrom_back.sv =====
// Back part: steps through the head group one result pixel per beat.
// Uses wrom_pkg for the group and status types.
module wrom_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrom_pkg::t_group  i_head,
    input  wrom_pkg::t_qstat  i_qstat,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_zero,
    output logic [7:0]        o_out_one,
    output logic [7:0]        o_out_two,
    output logic              o_run_end,
    output logic              o_frame_end
);
    import wrom_pkg::*;

    logic [1:0] r_sub;
    t_pix       cur;
    logic       last;

    assign cur         = i_head.pix[r_sub];
    assign last        = (r_sub == i_head.last_idx);
    assign o_out_valid = !i_qstat.empty;
    assign o_out_zero  = cur[7:0];
    assign o_out_one   = cur[15:8];
    assign o_out_two   = cur[23:16];
    assign o_run_end   = last;
    assign o_frame_end = last && i_head.fend;
    assign o_pop       = o_out_valid && i_out_ready && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_sub <= last ? 2'd0 : r_sub + 2'd1;
        end
    end

endmodule

// ===== rtl/white_region_outline_marker.sv =====
// Outline marker top level: front classifier, group queue, back emitter.
// A result group is registered in the classify stage and then written into the queue.
// Throughput: one pixel per cycle in and one result pixel per cycle out while
// neither side stalls; a last-row beat can yield up to three results, so input ready drops as the queue fills.
// Reset: synchronous active low; counters, queue and registers cleared,
// width and height set to one. Line buffers are not cleared.
module white_region_outline_marker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [wrom_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wrom_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_byte_zero,
    input  logic [7:0]                   i_byte_one,
    input  logic [7:0]                   i_byte_two,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_out_zero,
    output logic [7:0]                   o_out_one,
    output logic [7:0]                   o_out_two,
    output logic                         o_run_end,
    output logic                         o_frame_end
);
    import wrom_pkg::*;

    t_push  push;
    t_group head;
    t_qstat qstat;
    logic   pop;
    t_pix   in_pix;

    // Byte zero is the low byte of the packed pixel.
    assign in_pix = {i_byte_two, i_byte_one, i_byte_zero};

    // Front: hold position and line buffers, build the result group, if any, for each beat.
    // Input ready accounts for the group still in the classify stage.
    wrom_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pix      (in_pix),
        .i_qstat    (qstat),
        .o_push     (push)
    );

    // Queue: decouple classification from output stalls.
    wrom_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    // Back: drain each group one beat at a time, flag the run end.
    wrom_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_zero  (o_out_zero),
        .o_out_one   (o_out_one),
        .o_out_two   (o_out_two),
        .o_run_end   (o_run_end),
        .o_frame_end (o_frame_end)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for white_region_outline_marker: drives pixel frames,
// predicts every outlined result pixel and compares them. Depends on wrom_pkg.
module testbench;
    import wrom_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 65;
    localparam int EDGE_ITEMS    = 12;
    localparam int PRESSURE_ITEMS = 30;
    localparam int PRINT_CAP     = 30;
    localparam int LIMIT_CYCLES  = 500_000;

    // Indexes with no register behind them; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } t_idle;

    // One result pixel as it leaves the block.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       run_end;
        logic       frame_end;
    } t_outline_px;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [7:0]             byte_zero = '0;
    logic [7:0]             byte_one  = '0;
    logic [7:0]             byte_two  = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [7:0]             out_zero;
    logic [7:0]             out_one;
    logic [7:0]             out_two;
    logic                   run_end;
    logic                   frame_end;

    white_region_outline_marker DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_byte_zero (byte_zero),
        .i_byte_one  (byte_one),
        .i_byte_two  (byte_two),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_zero  (out_zero),
        .o_out_one   (out_one),
        .o_out_two   (out_two),
        .o_run_end   (run_end),
        .o_frame_end (frame_end)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the marker: line buffers, window, position, registers.
    // ------------------------------------------------------------------
    t_pix                    older_row [MAX_WIDTH];
    t_pix                    upper_row [MAX_WIDTH];
    t_pix                    window_px [3];
    t_pix                    above_left_px;
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;

    t_outline_px             pending_px[$];   // result pixels still owed by the block

    int unsigned pixels_in;
    int unsigned pixels_out;
    int unsigned frames_done;
    int unsigned reg_writes;
    int unsigned errors;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int          hold_left;                   // cycles the receiver still holds off

    function automatic void reset_shadow();
        foreach (window_px[k]) window_px[k] = '0;
        above_left_px = '0;
        col_pos       = 0;
        row_pos       = 0;
        width_reg     = WIDTH_REG_W'(1);
        height_reg    = HEIGHT_REG_W'(1);
        pending_px.delete();
    endfunction

    // Register value as the block uses it: zero acts as one, clamp at the top.
    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned top);
        if (v < 1) return 1;
        if (v > top) return top;
        return v;
    endfunction

    // Outline rule: a non-white pixel next to a white one inside the frame is marked.
    function automatic t_pix outline_of(input t_pix self,
                                        input logic up_ok, input t_pix up,
                                        input logic dn_ok, input t_pix dn,
                                        input logic lf_ok, input t_pix lf,
                                        input logic rt_ok, input t_pix rt);
        if (self == WHITE_PIX) return self;
        if ((up_ok && up == WHITE_PIX) || (dn_ok && dn == WHITE_PIX) ||
            (lf_ok && lf == WHITE_PIX) || (rt_ok && rt == WHITE_PIX))
            return MARK_PIX;
        return self;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WIDTH: begin
                width_reg = data[WIDTH_REG_W-1:0];
                col_pos   = 0;
                row_pos   = 0;
            end
            CFG_HEIGHT: begin
                height_reg = data[HEIGHT_REG_W-1:0];
                col_pos    = 0;
                row_pos    = 0;
            end
            default: ;
        endcase
    endfunction

    // Work out the result pixels one accepted input pixel releases, then advance.
    function automatic void predict_outline(input t_pix pix);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned n;
        t_pix        up_c;
        t_pix        rt;
        logic        rt_ok;
        logic        last_row;
        logic        frame_last;
        t_pix        res [3];
        t_outline_px px;
        w          = clamp_size(width_reg, MAX_WIDTH);
        h          = clamp_size(height_reg, MAX_HEIGHT);
        c          = col_pos;
        r          = row_pos;
        n          = 0;
        last_row   = (r + 1 == h);
        frame_last = last_row && (c + 1 == w);
        if (c >= w) c = w - 1;
        up_c = upper_row[c];
        // Pixel of the row above, now that its lower neighbour is known.
        if (r >= 1) begin
            rt_ok = (c + 1 < w);
            rt    = rt_ok ? upper_row[c + 1] : '0;
            res[n] = outline_of(up_c, r >= 2, older_row[c], 1'b1, pix,
                                c >= 1, above_left_px, rt_ok, rt);
            n++;
        end
        // Last row: its own left pixel, now that its right neighbour is known.
        if (last_row && c >= 1) begin
            res[n] = outline_of(window_px[0], r >= 1, above_left_px, 1'b0, '0,
                                c >= 2, window_px[1], 1'b1, pix);
            n++;
        end
        // Final pixel of the frame closes it.
        if (frame_last) begin
            res[n] = outline_of(pix, r >= 1, up_c, 1'b0, '0,
                                c >= 1, window_px[0], 1'b0, '0);
            n++;
        end
        for (int k = 0; k < n; k++) begin
            px.b0        = res[k][7:0];
            px.b1        = res[k][15:8];
            px.b2        = res[k][23:16];
            px.run_end   = (k == n - 1);
            px.frame_end = frame_last && (k == n - 1);
            pending_px.push_back(px);
        end
        above_left_px = up_c;
        older_row[c]  = up_c;
        upper_row[c]  = pix;
        window_px[2]  = window_px[1];
        window_px[1]  = window_px[0];
        window_px[0]  = pix;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    task automatic flag_error(input string msg);
        if (errors < PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d %s: got %0h, want %0h",
                                 pixels_out, name, got, want));
    endtask

    task automatic check_result();
        t_outline_px want;
        if (pending_px.size() == 0) begin
            flag_error($sformatf("result %0d arrived with nothing expected", pixels_out));
        end else begin
            want = pending_px.pop_front();
            check_field("out_zero", out_zero, want.b0);
            check_field("out_one", out_one, want.b1);
            check_field("out_two", out_two, want.b2);
            check_field("run_end", 8'(run_end), 8'(want.run_end));
            check_field("frame_end", 8'(frame_end), 8'(want.frame_end));
        end
        if (frame_end === 1'b1) frames_done++;
        pixels_out++;
    endtask

    // Sample everything at the rising edge: writes, result beats, input beats.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) apply_reg_write(cfg_idx, cfg_data);
            if (out_valid && out_ready) check_result();
            if (in_valid && in_ready) begin
                predict_outline({byte_two, byte_one, byte_zero});
                pixels_in++;
            end
        end
    end

    // Receiver: honor a requested hold-off first, else stall at random.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idle(input t_idle mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default:   begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
    endtask

    function automatic int unsigned sender_gap();
        int unsigned g;
        g = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) g++;
        return g;
    endfunction

    // Offer one pixel and hold it until the block takes the beat.
    task automatic send_pixel(input t_pix pix);
        int unsigned gap;
        int unsigned target;
        gap = sender_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        byte_zero <= pix[7:0];
        byte_one  <= pix[15:8];
        byte_two  <= pix[23:16];
        target = pixels_in + 1;
        do @(negedge clk); while (pixels_in < target);
    endtask

    // Drop valid, wait for every owed result, then let the pipe settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_px.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        write_reg(CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
    endtask

    // White, one bit short of white, or anything at all.
    function automatic t_pix rand_pixel(input int unsigned white_pct);
        int unsigned pick;
        t_pix        p;
        pick = $urandom_range(99);
        if (pick < white_pct) begin
            p = WHITE_PIX;
        end else if (pick < white_pct + (100 - white_pct) / 4) begin
            p = WHITE_PIX;
            p[$urandom_range(23)] = 1'b0;
        end else begin
            p = t_pix'($urandom);
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero in both registers acts as a 1x1 frame: every pixel passes straight through.
    task automatic test_single_pixels();
        set_idle(IDLE_BOTH);
        set_frame(0, 0);
        send_pixel(24'h000000);
        send_pixel(WHITE_PIX);
        send_pixel(24'h7F80FF);
        send_pixel(MARK_PIX);
        drain_results();
    endtask

    // 3x3 white center among near-whites, then an all-white 2x2.
    task automatic test_neighbour_frames();
        set_idle(IDLE_SEND);
        set_frame(3, 3);
        send_pixel(24'h123456);
        send_pixel(24'hFFFEFF);
        send_pixel(24'h800080);
        send_pixel(24'hFFFFFE);
        send_pixel(WHITE_PIX);
        send_pixel(24'hFEFFFF);
        send_pixel(24'h000000);
        send_pixel(24'h7FFFFF);
        send_pixel(24'hFF00FF);
        set_idle(IDLE_RECV);
        set_frame(2, 2);
        repeat (4) send_pixel(WHITE_PIX);
        drain_results();
    endtask

    // A partial frame, writes to unused indexes, then a restart by a height write.
    task automatic test_restart();
        set_idle(IDLE_RECV);
        set_frame(3, 4);
        repeat (5) send_pixel(rand_pixel(50));
        write_reg(CFG_SPARE_LO, 13'h1555);
        repeat (2) send_pixel(rand_pixel(50));
        write_reg(CFG_SPARE_HI, 13'h0AAA);
        send_pixel(rand_pixel(50));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(2));
        repeat (6) send_pixel(rand_pixel(50));
        drain_results();
    endtask

    // All-ones width clamps to the widest row; a width with only bit 11 set masks to zero
    // and acts as one, with the tallest frame behind it. Both runs stop early and the
    // next write restarts the frame.
    task automatic test_wide_and_tall();
        set_idle(IDLE_NONE);
        write_reg(CFG_WIDTH, 13'h1FFF);
        write_reg(CFG_HEIGHT, 13'h0000);
        repeat (EDGE_ITEMS) send_pixel(rand_pixel(50));
        write_reg(CFG_WIDTH, 13'h0800);
        write_reg(CFG_HEIGHT, 13'h1FFF);
        repeat (EDGE_ITEMS) send_pixel(rand_pixel(50));
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering, then a pause mid-frame.
    task automatic test_backpressure();
        set_idle(IDLE_NONE);
        set_frame(4, 30);
        hold_left = 400;
        repeat (PRESSURE_ITEMS) send_pixel(rand_pixel(60));
        drain_results();
        set_idle(IDLE_BOTH);
        repeat (PRESSURE_ITEMS) send_pixel(rand_pixel(60));
        drain_results();
    endtask

    // Random small frames, mostly complete; some cut short so the next write restarts.
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned white;
        int unsigned k;
        sent = 0;
        k    = 0;
        while (sent < RANDOM_ITEMS) begin
            set_idle(t_idle'(k % 4));
            k++;
            w = ($urandom_range(7) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
            h = $urandom_range(5, 1);
            set_frame(w, h);
            n = w * h;
            if ($urandom_range(99) < 15) n = $urandom_range(n, 1);
            white = $urandom_range(90);
            repeat (n) send_pixel(rand_pixel(white));
            sent += n;
        end
        drain_results();
    endtask

    initial begin
        pixels_in   = 0;
        pixels_out  = 0;
        frames_done = 0;
        reg_writes  = 0;
        errors      = 0;
        hold_left   = 0;
        set_idle(IDLE_NONE);
        reset_shadow();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_pixels();
        test_neighbour_frames();
        test_restart();
        test_wide_and_tall();
        test_backpressure();
        test_random_frames();
        drain_results();

        $display("Sent %0d pixels, checked %0d result pixels, saw %0d frame ends.",
                 pixels_in, pixels_out, frames_done);
        $display("Covered %0d register writes, sizes from 1x1 up to clamped extremes.",
                 reg_writes);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timed out with %0d result pixels still owed.", pending_px.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
